// ----- src/hsgt_pkg.sv -----
// ----------------------------------------------------------------------------
// hsgt_pkg: shared types and constants
// Word formats, op and status codes, and defaults for the slot grant table.
// ----------------------------------------------------------------------------
package hsgt_pkg;

	localparam int SLOT_COUNT_DEF = 256;
	localparam int COUNT_MAX = 511;

	typedef enum logic [1:0] {
		OP_ALLOC     = 2'd0,
		OP_DEALLOC   = 2'd1,
		OP_GRANT_ONE = 2'd2,
		OP_GRANT_ALL = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_ZERO = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [63:0] header_value;
		logic [63:0] satellite_value;
		logic [7:0]  slot_index;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  slot_out;
		logic        found;
		logic [8:0]  grant_count;
		logic        was_owned;
	} out_word_t;

	// Word carried around the ring of slot cells
	typedef struct packed {
		logic [63:0] hdr;
		logic [63:0] sat;
	} slot_word_t;

	// Per-cycle command from the sequencer to the ring
	typedef struct packed {
		logic        shift;
		logic        wr_en;
		logic        clr_sat;
		slot_word_t  wr_data;
	} ring_ctl_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_WALK = 2'd1,
		S_DONE = 2'd2
	} seq_state_t;

endpackage

// ----- src/hsgt_cell.sv -----
// ----------------------------------------------------------------------------
// hsgt_cell: one slot of the ring
// Holds one header and satellite word and hands it to the next cell on shift.
// ----------------------------------------------------------------------------
module hsgt_cell
	import hsgt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       shift,
	input  slot_word_t d,
	output slot_word_t q
);

	slot_word_t word_q;

	// Reset empties the slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q <= '0;
		end else if (shift) begin
			word_q <= d;
		end
	end

	assign q = word_q;

endmodule

// ----- src/hsgt_ring.sv -----
// ----------------------------------------------------------------------------
// hsgt_ring: rotating chain of slot cells
// The head cell is slot at position ptr; a shift moves every word one cell on.
// ----------------------------------------------------------------------------
module hsgt_ring
	import hsgt_pkg::*;
#(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  ring_ctl_t  ctl,
	output slot_word_t head
);

	slot_word_t cq [SLOT_COUNT];
	slot_word_t back;

	// Head word is rewritten on its way back into the tail
	always_comb begin
		back = cq[0];
		if (ctl.wr_en) begin
			back = ctl.wr_data;
		end else if (ctl.clr_sat) begin
			back.sat = '0;
		end
	end

	genvar g;
	generate
		for (g = 0; g < SLOT_COUNT; g++) begin : g_cell
			if (g == SLOT_COUNT - 1) begin : g_tail
				hsgt_cell u_cell (.clk, .arst_n, .shift(ctl.shift), .d(back), .q(cq[g]));
			end else begin : g_mid
				hsgt_cell u_cell (.clk, .arst_n, .shift(ctl.shift), .d(cq[g+1]),
					.q(cq[g]));
			end
		end
	endgenerate

	assign head = cq[0];

endmodule

// ----- src/hazard_slot_grant_table.sv -----
// ----------------------------------------------------------------------------
// hazard_slot_grant_table: slot table with allocate, release and grant
// Ring of SLOT_COUNT slot cells walked by a sequencer, one slot per cycle.
// ----------------------------------------------------------------------------
// Every accepted op that is not rejected (an out-of-range release is
// rejected too) rotates the whole ring, one slot passing the head cell
// per cycle, and then forms the result in S_DONE. An allocate whose only
// free slots lie below the search hint takes a second lap to reach the
// lowest of them. Rejected and out-of-range words leave the ring still
// and pass from S_WALK to S_DONE. One word is in work at a time; the
// input stalls until the result is taken, and the result register holds
// until taken while the ring stays still.
module hazard_slot_grant_table
	import hsgt_pkg::*;
#(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_word_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_word_t out_data
);

	localparam int PW = $clog2(SLOT_COUNT);
	localparam int CW = $clog2(SLOT_COUNT + 1);

	seq_state_t state_q, state_d;
	in_word_t   cmd_q;
	logic [PW-1:0] ptr_q;   // slot index at head cell
	logic [CW-1:0] step_q;  // slots walked
	logic [PW-1:0] hint_q;
	logic [PW-1:0] start_q;
	logic          done_q;   // alloc claimed / grant-one matched
	logic [8:0]    cnt_q;
	logic          owned_q;
	logic          rej_q;
	logic          fullflag_q; // alloc: second lap toward the wrapped candidate
	logic [PW-1:0] cand_q;     // lowest free slot below start
	logic          cand_v_q;
	logic [7:0]    slot_q;
	out_word_t     res_q;
	out_word_t     res_d;
	logic          res_v_q;

	ring_ctl_t  ctl;
	slot_word_t head;
	logic       take, last, match, is_free, pass2, want, relap;
	logic [PW-1:0] ptr_nx;

	hsgt_ring #(.SLOT_COUNT(SLOT_COUNT)) u_ring (.clk, .arst_n, .ctl, .head);

	assign in_stall = (state_q != S_IDLE) || res_v_q;
	assign take = in_valid && !in_stall;
	assign last = (step_q == CW'(SLOT_COUNT - 1));
	assign match = (head.hdr == cmd_q.header_value) && (head.sat == cmd_q.satellite_value);
	assign is_free = (head.hdr == '0);
	assign ptr_nx = (ptr_q == PW'(SLOT_COUNT - 1)) ? '0 : ptr_q + 1'b1;
	// alloc: slots below start are only taken if none at or above start is free
	assign pass2 = (ptr_q < start_q);
	// alloc: nothing free at or above start, go round again to the candidate
	assign relap = (state_q == S_WALK) && !rej_q && last && (cmd_q.op == OP_ALLOC) &&
		!done_q && !want && cand_v_q && !fullflag_q;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (take) state_d = S_WALK;
			S_WALK: if (rej_q || (last && !relap)) state_d = S_DONE;
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Ring commands during the walk
	always_comb begin
		ctl = '0;
		want = 1'b0;
		ctl.wr_data.hdr = cmd_q.header_value;
		ctl.wr_data.sat = cmd_q.satellite_value;
		if (state_q == S_WALK && !rej_q) begin
			ctl.shift = 1'b1;
			case (op_t'(cmd_q.op))
				OP_ALLOC: begin
					if (fullflag_q)
						want = (ptr_q == cand_q) && !done_q;
					else
						want = is_free && !done_q && !pass2;
					ctl.wr_en = want;
				end
				OP_DEALLOC: begin
					want = (ptr_q == PW'(cmd_q.slot_index));
					ctl.wr_en = want;
					ctl.wr_data = '0;
				end
				OP_GRANT_ONE: begin
					want = match && !done_q;
					ctl.clr_sat = want;
				end
				default: begin
					want = match;
					ctl.clr_sat = want;
				end
			endcase
		end
	end

	// Sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ptr_q <= '0;
			hint_q <= '0;
			res_v_q <= 1'b0;
			rej_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.shift) ptr_q <= ptr_nx;
			if (out_valid && !out_stall) res_v_q <= 1'b0;
			if (take) begin
				rej_q <= (in_data.op == OP_DEALLOC)
					? ({24'd0, in_data.slot_index} >= 32'(SLOT_COUNT))
					: (in_data.header_value == '0 || in_data.satellite_value == '0);
				if (in_data.op == OP_ALLOC && in_data.header_value != '0 &&
				    in_data.satellite_value != '0)
					hint_q <= (hint_q == PW'(SLOT_COUNT - 1)) ? '0 : hint_q + 1'b1;
			end
			if (state_q == S_DONE) res_v_q <= 1'b1;
		end
	end

	// Result word from the walk bookkeeping
	always_comb begin
		res_d = '0;
		if (rej_q && cmd_q.op != OP_DEALLOC) begin
			res_d.status = ST_ZERO;
		end else begin
			case (op_t'(cmd_q.op))
				OP_ALLOC: begin
					res_d.status = done_q ? ST_OK : ST_FULL;
					res_d.slot_out = slot_q;
				end
				OP_DEALLOC: res_d.was_owned = owned_q && !rej_q;
				OP_GRANT_ONE: res_d.found = done_q;
				default: res_d.grant_count = cnt_q;
			endcase
		end
	end

	// Walk bookkeeping (payload)
	always_ff @(posedge clk) begin
		if (take) begin
			cmd_q <= in_data;
			start_q <= hint_q;
			step_q <= '0;
			done_q <= 1'b0;
			cnt_q <= '0;
			owned_q <= 1'b0;
			slot_q <= '0;
			fullflag_q <= 1'b0;
			cand_q <= '0;
			cand_v_q <= 1'b0;
		end else if (ctl.shift) begin
			if (relap) begin
				step_q <= '0;
				fullflag_q <= 1'b1;
			end else begin
				step_q <= step_q + 1'b1;
			end
			// free slot seen before start: a second-lap candidate
			if (cmd_q.op == OP_ALLOC && is_free && pass2 && !cand_v_q && !fullflag_q) begin
				cand_q <= ptr_q;
				cand_v_q <= 1'b1;
			end
			if (want) begin
				done_q <= 1'b1;
				if (cmd_q.op == OP_ALLOC) slot_q <= 8'(ptr_q);
				if (cmd_q.op == OP_DEALLOC) owned_q <= (head.sat == '0);
				if (cmd_q.op == OP_GRANT_ALL && cnt_q != 9'(COUNT_MAX))
					cnt_q <= cnt_q + 1'b1;
			end
		end
		if (state_q == S_DONE)
			res_q <= res_d;
	end

	assign out_valid = res_v_q;
	assign out_data = res_q;

	// Assertions
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !take) else $error("accepted while busy");
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_data)))
		else $error("result dropped");
	a_ring_home: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && !rej_q) |-> (step_q == CW'(SLOT_COUNT)))
		else $error("ring not rotated fully");

endmodule

// ----- sim/hazard_slot_grant_table_test.sv -----
// ----------------------------------------------------------------------------
// hazard_slot_grant_table_test: self-checking bench for the slot grant table
// Drives allocate, release and grant words with random idling on both
// channels, predicts each result from a model of the table kept in the bench,
// and compares every result word field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hazard_slot_grant_table_test;
	import hsgt_pkg::*;

	localparam int NSLOT = SLOT_COUNT_DEF;
	localparam int IDLE_PCT = 13;
	localparam int WATCHDOG_LIMIT = 20000;

	// Table model: predicts one result word per accepted input word
	class slot_table_board;
		logic [63:0] hdr_tab [NSLOT];
		logic [63:0] sat_tab [NSLOT];
		int unsigned hint;
		out_word_t pending [$];
		int errors;

		function new();
			foreach (hdr_tab[i]) begin
				hdr_tab[i] = '0;
				sat_tab[i] = '0;
			end
			hint = 0;
			errors = 0;
		endfunction

		function void note_word(in_word_t w);
			out_word_t r;
			int slot;
			int cnt;
			r = '0;
			if (w.op == OP_DEALLOC) begin
				if (w.slot_index < NSLOT) begin
					r.was_owned = (sat_tab[w.slot_index] == 0);
					sat_tab[w.slot_index] = '0;
					hdr_tab[w.slot_index] = '0;
				end
			end else if (w.header_value == 0 || w.satellite_value == 0) begin
				r.status = ST_ZERO;
			end else if (w.op == OP_ALLOC) begin
				slot = -1;
				for (int k = 0; k < NSLOT; k++)
					if (slot < 0 && hdr_tab[(hint + k) % NSLOT] == 0)
						slot = (hint + k) % NSLOT;
				hint = (hint + 1) % NSLOT;
				if (slot < 0) begin
					r.status = ST_FULL;
				end else begin
					hdr_tab[slot] = w.header_value;
					sat_tab[slot] = w.satellite_value;
					r.slot_out = slot[7:0];
				end
			end else begin
				cnt = 0;
				for (int k = 0; k < NSLOT; k++) begin
					if ((w.op == OP_GRANT_ALL || cnt == 0) && hdr_tab[k] == w.header_value
							&& sat_tab[k] == w.satellite_value) begin
						sat_tab[k] = '0;
						if (cnt < COUNT_MAX)
							cnt++;
					end
				end
				if (w.op == OP_GRANT_ONE)
					r.found = (cnt != 0);
				else
					r.grant_count = cnt[8:0];
			end
			pending.push_back(r);
		endfunction

		function void check_word(out_word_t got);
			out_word_t e;
			if (pending.size() == 0) begin
				$error("result word with none expected: %h", got);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.status !== e.status) begin
				$error("status: expected %0d, got %0d", e.status, got.status);
				errors++;
			end
			if (got.slot_out !== e.slot_out) begin
				$error("slot_out: expected %0d, got %0d", e.slot_out, got.slot_out);
				errors++;
			end
			if (got.found !== e.found) begin
				$error("found: expected %0d, got %0d", e.found, got.found);
				errors++;
			end
			if (got.grant_count !== e.grant_count) begin
				$error("grant_count: expected %0d, got %0d", e.grant_count,
					got.grant_count);
				errors++;
			end
			if (got.was_owned !== e.was_owned) begin
				$error("was_owned: expected %0d, got %0d", e.was_owned, got.was_owned);
				errors++;
			end
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_word_t  in_data;
	logic      out_valid;
	logic      out_stall;
	out_word_t out_data;

	slot_table_board board;
	bit quiet_mode;      // no idling on either side
	bit hold_off_req;    // receiver stalls for a long stretch
	int idle_cycles;

	// Pool of live header/satellite pairs so grants hit real entries
	logic [63:0] pool_hdr [$];
	logic [63:0] pool_sat [$];

	hazard_slot_grant_table u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// Send one word, with random idle cycles ahead of it; valid stays up after
	// acceptance until the next idle cycle or drain lowers it
	task automatic send_word(in_word_t w);
		while (!quiet_mode && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		board.note_word(w);
	endtask

	task automatic send_op(op_t op, logic [63:0] h, logic [63:0] s, logic [7:0] idx);
		in_word_t w;
		w.op = op;
		w.header_value = h;
		w.satellite_value = s;
		w.slot_index = idx;
		send_word(w);
	endtask

	// Stop offering and wait for every expected result
	task automatic drain();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (board.pending.size() != 0);
	endtask

	// Random word, mostly well formed and aimed at live entries
	task automatic send_random();
		int sel;
		int p;
		logic [63:0] h;
		logic [63:0] s;
		sel = $urandom_range(99);
		h = rand64();
		s = rand64();
		if ($urandom_range(99) < 5) h = '0;
		if ($urandom_range(99) < 5) s = '0;
		if (sel < 40) begin
			// small value space so duplicates exist for grant-all
			if ($urandom_range(1)) begin
				h = 64'($urandom_range(4, 1));
				s = 64'($urandom_range(3, 1));
			end
			if (h != 0 && s != 0) begin
				pool_hdr.push_back(h);
				pool_sat.push_back(s);
				if (pool_hdr.size() > 64) begin
					void'(pool_hdr.pop_front());
					void'(pool_sat.pop_front());
				end
			end
			send_op(OP_ALLOC, h, s, 8'($urandom()));
		end else if (sel < 65) begin
			send_op(OP_DEALLOC, h, s, 8'($urandom()));
		end else begin
			if (pool_hdr.size() != 0 && $urandom_range(99) < 80) begin
				p = $urandom_range(pool_hdr.size() - 1);
				h = pool_hdr[p];
				s = pool_sat[p];
			end
			send_op(sel < 83 ? OP_GRANT_ONE : OP_GRANT_ALL, h, s, 8'($urandom()));
		end
	endtask

	// Receiver: random stall plus one long hold-off on request
	initial begin
		int hold;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold = 3000;
				hold_off_req = 1'b0;
			end
			if (hold > 0) begin
				hold--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !quiet_mode && ($urandom_range(99) < IDLE_PCT);
			end
		end
	end

	// Result check
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_word(out_data);
	end

	// Watchdog on cycles with no accepted word and no taken result
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("hazard_slot_grant_table_test: done, errors");
			$finish;
		end
	end

	initial begin
		board = new();
		quiet_mode = 1'b0;
		hold_off_req = 1'b0;
		idle_cycles = 0;
		arst_n = 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: zero arguments, extremes, every op and special case
		send_op(OP_ALLOC, '0, 64'd5, 8'd0);
		send_op(OP_ALLOC, 64'd5, '0, 8'd0);
		send_op(OP_GRANT_ONE, '0, '1, 8'd0);
		send_op(OP_GRANT_ALL, '1, '0, 8'd0);
		send_op(OP_ALLOC, '1, '1, 8'd0);
		send_op(OP_ALLOC, 64'd7, 64'd9, 8'd255);
		send_op(OP_ALLOC, 64'd7, 64'd9, 8'd0);
		send_op(OP_GRANT_ONE, 64'd7, 64'd9, 8'd0);
		send_op(OP_GRANT_ALL, 64'd7, 64'd9, 8'd0);
		send_op(OP_GRANT_ALL, 64'd7, 64'd9, 8'd0);
		send_op(OP_DEALLOC, '0, '0, 8'd1);
		send_op(OP_DEALLOC, '1, '1, 8'd2);
		send_op(OP_DEALLOC, '0, '0, 8'd255);
		send_op(OP_GRANT_ONE, '1, '1, 8'd0);
		send_op(OP_DEALLOC, 64'd3, 64'd3, 8'd0);
		send_op(OP_GRANT_ONE, 64'h8000_0000_0000_0000, 64'd1, 8'd0);
		drain();

		// Fill the table with one pair, overflow it, then grant all at once
		quiet_mode = 1'b1;
		for (int k = 0; k < NSLOT; k++)
			send_op(OP_ALLOC, 64'hA5, 64'h5A, 8'($urandom()));
		send_op(OP_ALLOC, 64'd1, 64'd1, 8'd0);
		send_op(OP_ALLOC, 64'd2, 64'd2, 8'd0);
		send_op(OP_GRANT_ALL, 64'hA5, 64'h5A, 8'd0);
		send_op(OP_DEALLOC, '0, '0, 8'd17);
		send_op(OP_DEALLOC, '0, '0, 8'd200);
		send_op(OP_ALLOC, 64'd11, 64'd12, 8'd0);
		send_op(OP_ALLOC, 64'd13, 64'd14, 8'd0);
		for (int k = 0; k < NSLOT; k++)
			send_op(OP_DEALLOC, '0, '0, k[7:0]);
		quiet_mode = 1'b0;

		// Long receiver hold-off while words keep coming
		hold_off_req = 1'b1;
		for (int k = 0; k < 20; k++)
			send_random();
		drain();

		// Random phase, with one quiet stretch and one pause to drain
		for (int k = 0; k < 550; k++) begin
			quiet_mode = (k >= 150 && k < 300);
			if (k == 400)
				drain();
			send_random();
		end
		quiet_mode = 1'b0;
		drain();
		repeat (NSLOT + 20) @(posedge clk);

		if (board.errors == 0 && board.pending.size() == 0)
			$display("hazard_slot_grant_table_test: done, clean");
		else
			$display("hazard_slot_grant_table_test: done, errors");
		$finish;
	end

endmodule

// ----- filelist.f -----
src/hsgt_pkg.sv
src/hsgt_cell.sv
src/hsgt_ring.sv
src/hazard_slot_grant_table.sv
sim/hazard_slot_grant_table_test.sv
